// ===== rtl/pss_pkg.sv =====
package pss_pkg;

	localparam int WORD_W = 32;
	localparam int GAIN_W = 18;
	localparam int GAIN_FRAC = 16;
	localparam int LIMIT_W = 31;
	localparam int COUNT_W = 4;
	localparam int CFG_W = 31;
	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] REG_INERTIA = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COGNITIVE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SOCIAL = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_COUNT = 3'd4;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_STEP = 1'b1;

	localparam logic [GAIN_W-1:0] INERTIA_RESET = 18'd58982;
	localparam logic [GAIN_W-1:0] COGNITIVE_RESET = 18'd58481;
	localparam logic [GAIN_W-1:0] SOCIAL_RESET = 18'd8405;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 31'd655360;
	localparam logic [COUNT_W-1:0] COUNT_RESET = 4'd5;

	// Shared multiplier request: two signed operands and a floor shift.
	typedef struct packed {
		logic signed [WORD_W:0] a;
		logic signed [WORD_W:0] b;
		logic [4:0] shift;
	} mul_req_t;

	function automatic logic signed [WORD_W-1:0] sat32(input logic signed [71:0] v);
		logic signed [71:0] hi;
		logic signed [71:0] lo;
		begin
			hi = 72'sd2147483647;
			lo = -72'sd2147483648;
			if (v > hi)
				sat32 = 32'sh7fffffff;
			else if (v < lo)
				sat32 = 32'sh80000000;
			else
				sat32 = v[WORD_W-1:0];
		end
	endfunction

endpackage

// ===== rtl/particle_swarm_step.sv =====
// Channel  Direction  Signals
// command  in         start, op, particle_index, load_pos_a/b, load_vel_a/b (busy is an output)
// result   out        done, result_kind, best_fitness, best_slot, best_pos_a/b
// config   in         cfg_we, cfg_index, cfg_data
// A load word is written at the accepting edge and done rises in the cycle after.
// A step word raises done once n particles have been scored and then updated, serialised on the one
// shared multiplier: the scoring pass covers every particle before the update pass begins.
// The update makes three products per coordinate and three more to rescore the new position.
// Reset clears control state and restores register defaults; the stores are not cleared.
// The receiver cannot stall: done is high for exactly one cycle per word.
module particle_swarm_step #(
	parameter int PARTICLES = 8,
	parameter int FRAC_BITS = 16
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	output logic                                   busy,
	input  logic                                   op,
	input  logic [2:0]                             particle_index,
	input  logic signed [pss_pkg::WORD_W-1:0]      load_pos_a,
	input  logic signed [pss_pkg::WORD_W-1:0]      load_pos_b,
	input  logic signed [pss_pkg::WORD_W-1:0]      load_vel_a,
	input  logic signed [pss_pkg::WORD_W-1:0]      load_vel_b,
	input  logic                                   cfg_we,
	input  logic [pss_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  logic [pss_pkg::CFG_W-1:0]              cfg_data,
	output logic                                   done,
	output logic                                   result_kind,
	output logic signed [pss_pkg::WORD_W-1:0]      best_fitness,
	output logic [2:0]                             best_slot,
	output logic signed [pss_pkg::WORD_W-1:0]      best_pos_a,
	output logic signed [pss_pkg::WORD_W-1:0]      best_pos_b
);

	localparam int IW = (PARTICLES > 1) ? $clog2(PARTICLES) : 1;
	localparam int CW = $clog2(PARTICLES + 1);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_SCORE = 4'd1;
	localparam logic [3:0] S_SCORE_END = 4'd2;
	localparam logic [3:0] S_UPD = 4'd3;
	localparam logic [3:0] S_DONE = 4'd4;
	localparam logic [3:0] S_LOAD = 4'd5;

	logic [3:0] state_q;
	logic [4:0] ph_q;
	logic [IW-1:0] idx_q;
	logic [CW-1:0] n_q;
	logic [pss_pkg::GAIN_W-1:0] inertia_q, cognitive_q, social_q;
	logic [pss_pkg::LIMIT_W-1:0] limit_q;
	logic [pss_pkg::COUNT_W-1:0] count_q;

	logic signed [31:0] pos_mem [PARTICLES][2];
	logic signed [31:0] vel_mem [PARTICLES][2];
	logic signed [31:0] pb_mem [PARTICLES][2];
	logic signed [31:0] old_score_q [PARTICLES];

	logic signed [71:0] acc_q;
	logic signed [31:0] best_fit_q, gbest_a_q, gbest_b_q;
	logic [IW-1:0] best_q;
	logic signed [31:0] newp_a_q, newp_b_q;

	pss_pkg::mul_req_t req;
	logic signed [71:0] prod_s1;

	pss_mul u_mul (.clk(clk), .req(req), .prod_s1(prod_s1));

	logic signed [31:0] xa, xb, cx, pbx, gbx, vx;
	logic signed [71:0] lim_w, pnew, fit_sum;
	logic signed [31:0] vn;
	logic j;

	assign xa = pos_mem[idx_q][0];
	assign xb = pos_mem[idx_q][1];
	// Update phases 0..3 handle coordinate a, 6..9 coordinate b.
	assign j = (ph_q >= 5'd6);
	assign cx = j ? xb : xa;
	assign pbx = pb_mem[idx_q][j];
	assign gbx = j ? gbest_b_q : gbest_a_q;
	assign vx = vel_mem[idx_q][j];
	assign lim_w = 72'(limit_q);
	assign busy = (state_q != S_IDLE);

	// Candidate positions for rescoring reuse newp registers after the move.
	logic signed [31:0] sa, sb;
	assign sa = (state_q == S_UPD) ? newp_a_q : xa;
	assign sb = (state_q == S_UPD) ? newp_b_q : xb;

	always_comb begin
		req.a = '0;
		req.b = '0;
		req.shift = 5'(FRAC_BITS);
		if (state_q == S_SCORE || (state_q == S_UPD && ph_q >= 5'd12)) begin
			unique case (ph_q[1:0])
				2'd0: begin req.a = 33'(sa); req.b = 33'(sa); end
				2'd1: begin req.a = 33'(sa); req.b = 33'(sb); end
				default: begin req.a = 33'(sb); req.b = 33'(sb); end
			endcase
		end else if (state_q == S_UPD) begin
			req.shift = 5'(pss_pkg::GAIN_FRAC);
			case (ph_q) inside
				5'd0, 5'd6: begin req.a = 33'(inertia_q); req.b = 33'(vx); end
				5'd1, 5'd7: begin req.a = 33'(cognitive_q); req.b = 33'(pbx) - 33'(cx); end
				default: begin req.a = 33'(social_q); req.b = 33'(gbx) - 33'(cx); end
			endcase
		end
	end

	// Products arrive in the cycle after the request (pss_mul registers them); ph_q indexes the request phase.
	assign fit_sum = acc_q + prod_s1 + 72'(2) * 72'(sa) + 72'(4) * 72'(sb)
		+ (72'sd3 <<< FRAC_BITS);
	assign vn = pss_pkg::sat32(acc_q + prod_s1);
	assign pnew = 72'(cx) + 72'(vn);

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start && op == pss_pkg::OP_LOAD
			&& 32'(particle_index) < PARTICLES) begin
			pos_mem[IW'(particle_index)][0] <= load_pos_a;
			pos_mem[IW'(particle_index)][1] <= load_pos_b;
			vel_mem[IW'(particle_index)][0] <= load_vel_a;
			vel_mem[IW'(particle_index)][1] <= load_vel_b;
			pb_mem[IW'(particle_index)][0] <= load_pos_a;
			pb_mem[IW'(particle_index)][1] <= load_pos_b;
		end
		if (state_q == S_UPD && (ph_q == 5'd3 || ph_q == 5'd9))
			vel_mem[idx_q][j] <= vn;
		if (state_q == S_UPD && ph_q == 5'd15) begin
			pos_mem[idx_q][0] <= newp_a_q;
			pos_mem[idx_q][1] <= newp_b_q;
			if (pss_pkg::sat32(fit_sum) > old_score_q[idx_q]) begin
				pb_mem[idx_q][0] <= newp_a_q;
				pb_mem[idx_q][1] <= newp_b_q;
			end
		end
		if (state_q == S_SCORE && ph_q == 5'd3)
			old_score_q[idx_q] <= pss_pkg::sat32(fit_sum);
	end

	function automatic logic signed [31:0] clampv(input logic signed [71:0] p,
		input logic signed [71:0] l);
		begin
			if (p > l) clampv = l[31:0];
			else if (p < -l) clampv = 32'(-l);
			else clampv = p[31:0];
		end
	endfunction

	always_ff @(posedge clk) begin
		if (state_q == S_UPD && (ph_q == 5'd3 || ph_q == 5'd9)) begin
			if (!j) newp_a_q <= clampv(pnew, lim_w);
			else newp_b_q <= clampv(pnew, lim_w);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inertia_q <= pss_pkg::INERTIA_RESET;
			cognitive_q <= pss_pkg::COGNITIVE_RESET;
			social_q <= pss_pkg::SOCIAL_RESET;
			limit_q <= pss_pkg::LIMIT_RESET;
			count_q <= pss_pkg::COUNT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				pss_pkg::REG_INERTIA: inertia_q <= cfg_data[pss_pkg::GAIN_W-1:0];
				pss_pkg::REG_COGNITIVE: cognitive_q <= cfg_data[pss_pkg::GAIN_W-1:0];
				pss_pkg::REG_SOCIAL: social_q <= cfg_data[pss_pkg::GAIN_W-1:0];
				pss_pkg::REG_LIMIT: limit_q <= cfg_data;
				pss_pkg::REG_COUNT: count_q <= cfg_data[pss_pkg::COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ph_q <= '0;
			idx_q <= '0;
			n_q <= '0;
			done <= 1'b0;
			result_kind <= 1'b0;
			best_fitness <= '0;
			best_slot <= '0;
			best_pos_a <= '0;
			best_pos_b <= '0;
			acc_q <= '0;
			best_fit_q <= '0;
			best_q <= '0;
			gbest_a_q <= '0;
			gbest_b_q <= '0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					ph_q <= '0;
					idx_q <= '0;
					acc_q <= '0;
					if (count_q == 4'd0)
						n_q <= CW'(1);
					else if (32'(count_q) > PARTICLES)
						n_q <= CW'(PARTICLES);
					else
						n_q <= CW'(count_q);
					if (start)
						state_q <= (op == pss_pkg::OP_STEP) ? S_SCORE : S_LOAD;
				end
				S_LOAD: begin
					done <= 1'b1;
					result_kind <= 1'b0;
					best_fitness <= '0;
					best_slot <= '0;
					best_pos_a <= '0;
					best_pos_b <= '0;
					state_q <= S_IDLE;
				end
				S_SCORE: begin
					unique case (ph_q)
						5'd0: begin
							acc_q <= '0;
							ph_q <= 5'd1;
						end
						5'd1: begin
							acc_q <= prod_s1;
							ph_q <= 5'd2;
						end
						5'd2: begin
							acc_q <= acc_q - prod_s1;
							ph_q <= 5'd3;
						end
						default: begin
							if (idx_q == '0 || pss_pkg::sat32(fit_sum) > best_fit_q) begin
								best_fit_q <= pss_pkg::sat32(fit_sum);
								best_q <= idx_q;
							end
							ph_q <= '0;
							acc_q <= '0;
							if (32'(idx_q) + 1 >= 32'(n_q))
								state_q <= S_SCORE_END;
							else
								idx_q <= idx_q + 1'b1;
						end
					endcase
				end
				S_SCORE_END: begin
					gbest_a_q <= pos_mem[best_q][0];
					gbest_b_q <= pos_mem[best_q][1];
					idx_q <= '0;
					ph_q <= '0;
					acc_q <= '0;
					state_q <= S_UPD;
				end
				S_UPD: begin
					case (ph_q) inside
						5'd0, 5'd6, 5'd12: begin
							acc_q <= '0;
							ph_q <= ph_q + 5'd1;
						end
						5'd1, 5'd7, 5'd13: begin
							acc_q <= prod_s1;
							ph_q <= ph_q + 5'd1;
						end
						5'd2, 5'd8: begin
							acc_q <= acc_q + prod_s1;
							ph_q <= ph_q + 5'd1;
						end
						5'd14: begin
							acc_q <= acc_q - prod_s1;
							ph_q <= 5'd15;
						end
						5'd3: begin
							acc_q <= '0;
							ph_q <= 5'd6;
						end
						5'd9: begin
							acc_q <= '0;
							ph_q <= 5'd12;
						end
						5'd15: begin
							ph_q <= '0;
							acc_q <= '0;
							if (32'(idx_q) + 1 >= 32'(n_q))
								state_q <= S_DONE;
							else
								idx_q <= idx_q + 1'b1;
						end
						default: ph_q <= '0;
					endcase
				end
				S_DONE: begin
					done <= 1'b1;
					result_kind <= 1'b1;
					best_fitness <= best_fit_q;
					best_slot <= 3'(best_q);
					best_pos_a <= gbest_a_q;
					best_pos_b <= gbest_b_q;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done held for two cycles");
	a_busy_done: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("done while busy");
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> (32'(idx_q) < PARTICLES)) else $error("slot out of range");
	a_start_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("accepted word not started");
`endif

endmodule

// ===== rtl/pss_mul.sv =====
module pss_mul (
	input  logic                        clk,
	input  pss_pkg::mul_req_t           req,
	output logic signed [71:0]          prod_s1
);

	logic signed [65:0] full;

	assign full = req.a * req.b;

	always_ff @(posedge clk) begin
		prod_s1 <= 72'(full >>> req.shift);
	end

endmodule

// ===== tb/sv/tb.sv =====
module tb;

	typedef struct {
		logic              kind;
		logic signed [31:0] fit;
		logic [2:0]         slot;
		logic signed [31:0] pa;
		logic signed [31:0] pb;
	} swarm_res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic op = pss_pkg::OP_LOAD;
	logic [2:0] particle_index = '0;
	logic signed [31:0] load_pos_a = '0;
	logic signed [31:0] load_pos_b = '0;
	logic signed [31:0] load_vel_a = '0;
	logic signed [31:0] load_vel_b = '0;
	logic cfg_we = 1'b0;
	logic [pss_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [pss_pkg::CFG_W-1:0] cfg_data = '0;
	logic done;
	logic result_kind;
	logic signed [31:0] best_fitness;
	logic [2:0] best_slot;
	logic signed [31:0] best_pos_a;
	logic signed [31:0] best_pos_b;

	swarm_res_t pending_words[$];
	int errors = 0;
	int stall_cycles = 0;
	localparam int STALL_LIMIT = 4000;

	logic [17:0] sh_inertia = pss_pkg::INERTIA_RESET;
	logic [17:0] sh_cognitive = pss_pkg::COGNITIVE_RESET;
	logic [17:0] sh_social = pss_pkg::SOCIAL_RESET;
	logic [30:0] sh_limit = pss_pkg::LIMIT_RESET;
	logic [3:0] sh_count = pss_pkg::COUNT_RESET;
	logic signed [31:0] pos_m [8][2];
	logic signed [31:0] vel_m [8][2];
	logic signed [31:0] pbest_m [8][2];

	particle_swarm_step u_dut (.*);

	always #5 clk = ~clk;

	function automatic logic signed [31:0] clip32(longint v);
		if (v > 64'sd2147483647)
			return 32'sh7fffffff;
		if (v < -64'sd2147483648)
			return 32'sh80000000;
		return v[31:0];
	endfunction

	function automatic logic signed [31:0] objective(logic signed [31:0] a, logic signed [31:0] b);
		longint x, y, s;
		x = a;
		y = b;
		s = ((x * x) >>> 16) - ((x * y) >>> 16) + ((y * y) >>> 16) + 2 * x + 4 * y
			+ (longint'(3) << 16);
		return clip32(s);
	endfunction

	function automatic longint gained(logic [17:0] g, longint d);
		longint gl;
		gl = g;
		return (gl * d) >>> 16;
	endfunction

	function automatic swarm_res_t predict_step();
		swarm_res_t r;
		int n, bi;
		logic signed [31:0] old_fit [8];
		logic signed [31:0] gb [2];
		longint x, v, p, lim;
		logic signed [31:0] vn;
		n = sh_count;
		if (n == 0)
			n = 1;
		if (n > 8)
			n = 8;
		lim = sh_limit;
		bi = 0;
		for (int i = 0; i < n; i++)
			old_fit[i] = objective(pos_m[i][0], pos_m[i][1]);
		for (int i = 1; i < n; i++)
			if (old_fit[i] > old_fit[bi])
				bi = i;
		gb[0] = pos_m[bi][0];
		gb[1] = pos_m[bi][1];
		for (int i = 0; i < n; i++) begin
			for (int j = 0; j < 2; j++) begin
				x = pos_m[i][j];
				v = gained(sh_inertia, vel_m[i][j]) + gained(sh_cognitive, pbest_m[i][j] - x)
					+ gained(sh_social, gb[j] - x);
				vn = clip32(v);
				p = x + vn;
				if (p > lim)
					p = lim;
				else if (p < -lim)
					p = -lim;
				vel_m[i][j] = vn;
				pos_m[i][j] = p[31:0];
			end
			if (objective(pos_m[i][0], pos_m[i][1]) > old_fit[i]) begin
				pbest_m[i][0] = pos_m[i][0];
				pbest_m[i][1] = pos_m[i][1];
			end
		end
		r.kind = 1'b1;
		r.fit = old_fit[bi];
		r.slot = bi[2:0];
		r.pa = gb[0];
		r.pb = gb[1];
		return r;
	endfunction

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
		errors++;
	endtask

	task automatic send_word(logic o, logic [2:0] idx, logic [31:0] pa, logic [31:0] pb,
		logic [31:0] va, logic [31:0] vb);
		swarm_res_t r;
		@(negedge clk);
		start <= 1'b1;
		op <= o;
		particle_index <= idx;
		load_pos_a <= pa;
		load_pos_b <= pb;
		load_vel_a <= va;
		load_vel_b <= vb;
		forever begin
			@(posedge clk);
			if (!busy)
				break;
		end
		if (o == pss_pkg::OP_LOAD) begin
			pos_m[idx][0] = pa;
			pos_m[idx][1] = pb;
			vel_m[idx][0] = va;
			vel_m[idx][1] = vb;
			pbest_m[idx][0] = pa;
			pbest_m[idx][1] = pb;
			r = '{1'b0, '0, '0, '0, '0};
		end else begin
			r = predict_step();
		end
		pending_words.push_back(r);
	endtask

	task automatic pause(int cycles);
		repeat (cycles) begin
			@(negedge clk);
			start <= 1'b0;
		end
	endtask

	task automatic random_gap(bit quiet);
		int r;
		r = $urandom_range(0, 9);
		if (quiet || r < 5)
			return;
		pause(r < 9 ? $urandom_range(1, 3) : $urandom_range(10, 40));
	endtask

	task automatic drain();
		pause(1);
		wait (pending_words.size() == 0);
		repeat (5) @(negedge clk);
	endtask

	task automatic write_reg(logic [pss_pkg::CFG_IDX_W-1:0] idx, logic [pss_pkg::CFG_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			pss_pkg::REG_INERTIA: sh_inertia = val[17:0];
			pss_pkg::REG_COGNITIVE: sh_cognitive = val[17:0];
			pss_pkg::REG_SOCIAL: sh_social = val[17:0];
			pss_pkg::REG_LIMIT: sh_limit = val[30:0];
			pss_pkg::REG_COUNT: sh_count = val[3:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [31:0] rand_coord();
		int r;
		r = $urandom_range(0, 9);
		if (r < 5)
			return $signed($urandom_range(0, 2621440)) - 1310720;
		if (r < 8)
			return $urandom;
		return r == 8 ? 32'h7fffffff : 32'h80000000;
	endfunction

	task automatic load_rand(logic [2:0] idx);
		send_word(pss_pkg::OP_LOAD, idx, rand_coord(), rand_coord(), rand_coord(), rand_coord());
	endtask

	task automatic step_word();
		send_word(pss_pkg::OP_STEP, 3'($urandom), $urandom, $urandom, $urandom, $urandom);
	endtask

	task automatic test_directed();
		send_word(pss_pkg::OP_LOAD, 3'd0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
			32'h80000000);
		send_word(pss_pkg::OP_LOAD, 3'd1, 32'h80000000, 32'h80000000, 32'h80000000,
			32'h7fffffff);
		send_word(pss_pkg::OP_LOAD, 3'd2, 0, 0, 0, 0);
		send_word(pss_pkg::OP_LOAD, 3'd3, 32'hffffffff, 32'h00010000, 32'hffffffff,
			32'h00000001);
		send_word(pss_pkg::OP_LOAD, 3'd4, 32'h80000000, 32'h7fffffff, 0, 0);
		for (int i = 5; i < 8; i++)
			send_word(pss_pkg::OP_LOAD, 3'(i), 32'h00020000, 32'hfffe0000, 32'h00008000,
				32'hffff8000);
		step_word();
		step_word();
		for (int i = 0; i < 8; i++)
			send_word(pss_pkg::OP_LOAD, 3'(i), 32'h00010000, 32'h00010000, 0, 0);
		step_word();
		drain();
		write_reg(pss_pkg::REG_COUNT, 31'd8);
		step_word();
		step_word();
		drain();
	endtask

	task automatic test_register_extremes();
		logic [pss_pkg::CFG_W-1:0] gains [4] = '{0, 18'h3ffff, 18'h10000, 31'h7fffffff};
		logic [pss_pkg::CFG_W-1:0] lims [3] = '{0, 31'h7fffffff, 655360};
		logic [pss_pkg::CFG_W-1:0] counts [5] = '{0, 1, 8, 15, 9};
		for (int k = 0; k < 5; k++) begin
			write_reg(pss_pkg::REG_INERTIA, gains[$urandom_range(0, 3)]);
			write_reg(pss_pkg::REG_COGNITIVE, gains[$urandom_range(0, 3)]);
			write_reg(pss_pkg::REG_SOCIAL, gains[$urandom_range(0, 3)]);
			write_reg(pss_pkg::REG_LIMIT, lims[k % 3]);
			write_reg(pss_pkg::REG_COUNT, counts[k]);
			for (int i = 0; i < 8; i++)
				load_rand(3'(i));
			step_word();
			step_word();
			drain();
		end
	endtask

	task automatic test_random_swarm();
		bit quiet;
		for (int ph = 0; ph < 8; ph++) begin
			write_reg(pss_pkg::REG_INERTIA,
				31'($urandom_range(0, 9) < 7 ? $urandom_range(0, 70000) : $urandom));
			write_reg(pss_pkg::REG_COGNITIVE,
				31'($urandom_range(0, 9) < 7 ? $urandom_range(0, 70000) : $urandom));
			write_reg(pss_pkg::REG_SOCIAL,
				31'($urandom_range(0, 9) < 7 ? $urandom_range(0, 70000) : $urandom));
			write_reg(pss_pkg::REG_LIMIT,
				31'($urandom_range(0, 3) != 0 ? $urandom_range(0, 2000000) : $urandom));
			write_reg(pss_pkg::REG_COUNT, 31'($urandom_range(0, 15)));
			quiet = ph[0];
			for (int i = 0; i < 8; i++) begin
				load_rand(3'(i));
				random_gap(quiet);
			end
			for (int k = 0; k < 65; k++) begin
				if ($urandom_range(0, 2) == 0)
					load_rand(3'($urandom));
				else
					step_word();
				random_gap(quiet);
			end
			drain();
		end
	endtask

	always @(posedge clk) begin
		swarm_res_t e;
		if ((start && !busy) || done)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (done) begin
			if (pending_words.size() == 0) begin
				$display("unexpected result word at %0t", $time);
				errors++;
			end else begin
				e = pending_words.pop_front();
				if (result_kind !== e.kind)
					report("result_kind", 32'(result_kind), 32'(e.kind));
				if (best_fitness !== e.fit)
					report("best_fitness", best_fitness, e.fit);
				if (best_slot !== e.slot)
					report("best_slot", 32'(best_slot), 32'(e.slot));
				if (best_pos_a !== e.pa)
					report("best_pos_a", best_pos_a, e.pa);
				if (best_pos_b !== e.pb)
					report("best_pos_b", best_pos_b, e.pb);
			end
		end
		if (stall_cycles >= STALL_LIMIT) begin
			$display("FAIL particle_swarm_step");
			$finish;
		end
	end

	initial begin
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_register_extremes();
		test_random_swarm();
		drain();
		repeat (20) @(posedge clk);
		if (errors == 0 && pending_words.size() == 0)
			$display("PASS particle_swarm_step");
		else
			$display("FAIL particle_swarm_step");
		$finish;
	end

endmodule
